// ===== src/lstk_pkg.sv =====
package lstk_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int WORD_WIDTH  = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // request action codes
  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_SEARCH = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL  = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

  // movement of the cell chain each cycle
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPORT
  } state_t;

  // control handed from the controller to every cell
  typedef struct packed {
    shift_t                  mode;
    logic [WORD_WIDTH-1:0]   push_data;
  } chain_ctl_t;

  // operand to stored word width, sign extended or truncated
  function automatic logic [WORD_WIDTH-1:0] to_word(input logic [31:0] v);
    return WORD_WIDTH'($signed(v));
  endfunction

  // stored word to the 32-bit result field
  function automatic logic [31:0] to_result(input logic [WORD_WIDTH-1:0] w);
    return 32'(w);
  endfunction

endpackage

// ===== src/lstk_cell.sv =====
module lstk_cell import lstk_pkg::*; (
  input  logic                  clk,
  input  chain_ctl_t            ctl,
  input  logic [WORD_WIDTH-1:0] from_above,
  input  logic [WORD_WIDTH-1:0] from_below,
  output logic [WORD_WIDTH-1:0] entry
);

  logic [WORD_WIDTH-1:0] entry_next;

  // pick the neighbor that moves into this cell
  always_comb begin
    case (ctl.mode)
      SH_DOWN: entry_next = from_above;
      SH_UP:   entry_next = from_below;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== src/lstk_ctrl.sv =====
module lstk_ctrl import lstk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            action,
  input  logic [31:0]           operand_value,
  input  logic [5:0]            position_query,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [31:0]           result_value,
  output logic [5:0]            result_position,
  output logic [6:0]            fill_level,
  output logic                  empty_flag,
  input  logic [WORD_WIDTH-1:0] top_entry,
  input  logic [WORD_WIDTH-1:0] next_entry,
  output chain_ctl_t            chain
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [2:0]            req_action;
  logic [WORD_WIDTH-1:0] req_key;
  logic [5:0]            req_pos;
  logic [IDX_W-1:0]      scan_idx;
  logic                  found;
  logic [IDX_W-1:0]      found_pos;
  logic [WORD_WIDTH-1:0] found_val;
  logic                  out_free;
  logic                  out_load;
  logic                  in_fire;
  logic                  scan_hit;
  logic                  scan_last;
  logic [1:0]            res_status;
  logic [31:0]           res_value;
  logic [IDX_W-1:0]      res_pos;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign scan_last = (scan_idx == IDX_W'(STACK_DEPTH - 1));

  // one entry per cycle passes the top cell while the chain rotates
  always_comb begin
    scan_hit = 1'b0;
    if (state == S_SCAN && !found && (CNT_W'(scan_idx) < count)) begin
      if (req_action == ACT_SEARCH) begin
        scan_hit = (top_entry == req_key);
      end else begin
        scan_hit = (32'(scan_idx) == 32'(req_pos));
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_SEARCH || action == ACT_READ) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_last) state_next = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // chain control, fill count and result
  always_comb begin
    chain.mode      = SH_HOLD;
    chain.push_data = req_key;
    count_next      = count;
    out_load        = 1'b0;
    res_status      = STAT_OK;
    res_value       = '0;
    res_pos         = '0;
    unique case (state)
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (req_action)
            ACT_PUSH: begin
              if (count < CNT_W'(STACK_DEPTH)) begin
                chain.mode = SH_DOWN;
                count_next = count + CNT_W'(1);
                res_value  = to_result(req_key);
              end else begin
                res_status = STAT_PUSH_FULL;
                res_value  = to_result(top_entry);
              end
            end
            ACT_POP: begin
              if (count == '0) begin
                res_status = STAT_POP_EMPTY;
              end else begin
                chain.mode = SH_UP;
                count_next = count - CNT_W'(1);
                if (count != CNT_W'(1)) res_value = to_result(next_entry);
              end
            end
            ACT_CLEAR: begin
              count_next = '0;
            end
            default: begin
              if (count != '0) res_value = to_result(top_entry);
            end
          endcase
        end
      end
      S_SCAN: begin
        chain.mode = SH_UP;
      end
      S_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (found) begin
            res_value = to_result(found_val);
            res_pos   = found_pos;
          end else begin
            res_status = STAT_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      scan_idx  <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (scan_hit) found <= 1'b1;
      end
    end
  end

  // request, scan capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_action <= action;
      req_key    <= to_word(operand_value);
      req_pos    <= position_query;
    end
    if (scan_hit) begin
      found_pos <= scan_idx;
      found_val <= top_entry;
    end
    if (out_load) begin
      status          <= res_status;
      result_value    <= res_value;
      result_position <= 6'(res_pos);
      fill_level      <= 7'(count_next);
      empty_flag      <= (count_next == '0);
    end
  end

endmodule

// ===== src/searchable_lifo_stack_core.sv =====
// Searchable LIFO stack built as a chain of storage cells, top entry in cell 0.
// Input transaction: in_valid/in_ready with action, operand_value and
// position_query. Output transaction: out_valid/out_ready with status,
// result_value, result_position, fill_level and empty_flag; one result for
// every accepted request, in order.
// Push, pop, clear and unknown actions shift the chain by at most one cell;
// the execute state loads their result once the output register is free.
// Search and read-by-position rotate the whole chain through the top cell,
// one entry per cycle, through all STACK_DEPTH cells so the stack ends in
// its original order; the report state then loads their result once the
// output register is free. The rotation length sets their throughput.
// One request is processed at a time; in_ready is high whenever the
// controller is idle, even while the previous result waits in the output
// register. When the receiver stalls, a finished result holds in the output
// register and the next request waits before it changes the stack.
// Synchronous reset empties the stack (fill level 0) and drops any pending
// result; stored words are not cleared and are never read before a push.
module searchable_lifo_stack_core import lstk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] operand_value,
  input  logic [5:0]  position_query,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] result_value,
  output logic [5:0]  result_position,
  output logic [6:0]  fill_level,
  output logic        empty_flag
);

  chain_ctl_t            chain;
  logic [WORD_WIDTH-1:0] entries [STACK_DEPTH];

  // controller: request decode, scan sequencing and output register
  lstk_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .operand_value   (operand_value),
    .position_query  (position_query),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .result_value    (result_value),
    .result_position (result_position),
    .fill_level      (fill_level),
    .empty_flag      (empty_flag),
    .top_entry       (entries[0]),
    .next_entry      (entries[1]),
    .chain           (chain)
  );

  // row of cells; shifting up wraps the entry of the top cell into the last cell
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      lstk_cell u_cell (
        .clk        (clk),
        .ctl        (chain),
        .from_above (chain.push_data),
        .from_below (entries[1]),
        .entry      (entries[0])
      );
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      lstk_cell u_cell (
        .clk        (clk),
        .ctl        (chain),
        .from_above (entries[i-1]),
        .from_below (entries[0]),
        .entry      (entries[i])
      );
    end else begin : g_mid
      lstk_cell u_cell (
        .clk        (clk),
        .ctl        (chain),
        .from_above (entries[i-1]),
        .from_below (entries[i+1]),
        .entry      (entries[i])
      );
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import lstk_pkg::*;

  // reserved action codes, the block treats them as no-ops
  localparam logic [2:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI  = 3'd7;

  localparam int RANDOM_ITEMS = 1325;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = STACK_DEPTH + 8;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  position;
    logic [6:0]  fill;
    logic        empty;
  } lifo_result_t;

  typedef struct packed {
    logic [2:0]   act;
    logic [31:0]  operand;
    logic [5:0]   pos;
    logic         typed;
    lifo_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIX
  } segment_t;

  localparam int DIR_COUNT = 24;

  // directed requests, typed results where they follow directly
  localparam stim_row_t DIRECTED [DIR_COUNT] = '{
    '{ACT_POP,     32'h0000_0000, 6'd0,  1'b1, '{STAT_POP_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_SEARCH,  32'h0000_0000, 6'd0,  1'b1, '{STAT_NOT_FOUND, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_READ,    32'h0000_0000, 6'd0,  1'b1, '{STAT_NOT_FOUND, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_RSVD_HI, 32'hFFFF_FFFF, 6'd63, 1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_CLEAR,   32'h0000_0000, 6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_PUSH,    32'h8000_0000, 6'd0,  1'b1, '{STAT_OK, 32'h8000_0000, 6'd0, 7'd1, 1'b0}},
    '{ACT_PUSH,    32'h7FFF_FFFF, 6'd63, 1'b1, '{STAT_OK, 32'h7FFF_FFFF, 6'd0, 7'd2, 1'b0}},
    '{ACT_PUSH,    32'h0000_0000, 6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd3, 1'b0}},
    '{ACT_PUSH,    32'hFFFF_FFFF, 6'd0,  1'b1, '{STAT_OK, 32'hFFFF_FFFF, 6'd0, 7'd4, 1'b0}},
    '{ACT_SEARCH,  32'h8000_0000, 6'd0,  1'b0, '0},
    '{ACT_SEARCH,  32'h1234_5678, 6'd0,  1'b1, '{STAT_NOT_FOUND, 32'h0, 6'd0, 7'd4, 1'b0}},
    '{ACT_READ,    32'h0000_0000, 6'd3,  1'b0, '0},
    '{ACT_READ,    32'h0000_0000, 6'd63, 1'b1, '{STAT_NOT_FOUND, 32'h0, 6'd0, 7'd4, 1'b0}},
    '{ACT_READ,    32'h0000_0000, 6'd4,  1'b1, '{STAT_NOT_FOUND, 32'h0, 6'd0, 7'd4, 1'b0}},
    '{ACT_RSVD_LO, 32'h5555_5555, 6'd21, 1'b0, '0},
    '{ACT_RSVD_MID, 32'hAAAA_AAAA, 6'd42, 1'b0, '0},
    '{ACT_PUSH,    32'h7FFF_FFFF, 6'd0,  1'b0, '0},
    '{ACT_SEARCH,  32'h7FFF_FFFF, 6'd0,  1'b0, '0},
    '{ACT_POP,     32'h0000_0000, 6'd0,  1'b0, '0},
    '{ACT_SEARCH,  32'hFFFF_FFFF, 6'd0,  1'b0, '0},
    '{ACT_CLEAR,   32'hFFFF_FFFF, 6'd63, 1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_PUSH,    32'h5A5A_5A5A, 6'd0,  1'b1, '{STAT_OK, 32'h5A5A_5A5A, 6'd0, 7'd1, 1'b0}},
    '{ACT_POP,     32'h0000_0000, 6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{ACT_POP,     32'h0000_0000, 6'd0,  1'b1, '{STAT_POP_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = ACT_PUSH;
  logic [31:0] operand_value = '0;
  logic [5:0]  position_query = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_value;
  logic [5:0]  result_position;
  logic [6:0]  fill_level;
  logic        empty_flag;

  // shadow copy of the stack contents, entry 0 at the bottom
  logic [WORD_WIDTH-1:0] stack_words [STACK_DEPTH];
  int                    stack_fill = 0;

  lifo_result_t responses_due [$];
  int           mismatches = 0;
  bit           steady_run = 1'b0;

  searchable_lifo_stack_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .operand_value   (operand_value),
    .position_query  (position_query),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .result_value    (result_value),
    .result_position (result_position),
    .fill_level      (fill_level),
    .empty_flag      (empty_flag)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[searchable_lifo_stack_core] ERROR");
    $finish;
  end

  function automatic logic [WORD_WIDTH-1:0] top_entry();
    if (stack_fill == 0) return '0;
    return stack_words[stack_fill-1];
  endfunction

  // apply one request to the shadow stack and return the result it gives
  function automatic lifo_result_t lifo_response(input logic [2:0] act,
                                                 input logic [31:0] operand,
                                                 input logic [5:0] pos);
    lifo_result_t          r;
    logic [WORD_WIDTH+31:0] ext;
    logic [WORD_WIDTH-1:0]  word;
    logic [WORD_WIDTH-1:0]  hit;
    int                     i;
    bit                     found;
    ext   = {{WORD_WIDTH{operand[31]}}, operand};
    word  = ext[WORD_WIDTH-1:0];
    r     = '0;
    hit   = '0;
    found = 1'b0;
    case (act)
      ACT_PUSH: begin
        if (stack_fill < STACK_DEPTH) begin
          stack_words[stack_fill] = word;
          stack_fill++;
        end else begin
          r.status = STAT_PUSH_FULL;
        end
        hit = top_entry();
      end
      ACT_POP: begin
        if (stack_fill == 0) begin
          r.status = STAT_POP_EMPTY;
        end else begin
          stack_fill--;
          hit = top_entry();
        end
      end
      ACT_SEARCH: begin
        r.status = STAT_NOT_FOUND;
        for (i = 0; i < stack_fill && !found; i++) begin
          if (stack_words[stack_fill-1-i] == word) begin
            found      = 1'b1;
            r.status   = STAT_OK;
            hit        = word;
            r.position = 6'(i);
          end
        end
      end
      ACT_READ: begin
        if (int'(pos) < stack_fill) begin
          hit        = stack_words[stack_fill-1-int'(pos)];
          r.position = pos;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      ACT_CLEAR: stack_fill = 0;
      default:   hit = top_entry();
    endcase
    ext     = {32'b0, hit};
    r.value = ext[31:0];
    r.fill  = 7'(stack_fill);
    r.empty = (stack_fill == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // compare one result transaction with the oldest one due
  task automatic check_result();
    lifo_result_t want;
    if (responses_due.size() == 0) begin
      report_mismatch("result with none due, value", result_value, 32'h0);
    end else begin
      want = responses_due.pop_front();
      if (status !== want.status)
        report_mismatch("status", 32'(status), 32'(want.status));
      if (result_value !== want.value)
        report_mismatch("result_value", result_value, want.value);
      if (result_position !== want.position)
        report_mismatch("result_position", 32'(result_position), 32'(want.position));
      if (fill_level !== want.fill)
        report_mismatch("fill_level", 32'(fill_level), 32'(want.fill));
      if (empty_flag !== want.empty)
        report_mismatch("empty_flag", 32'(empty_flag), 32'(want.empty));
    end
  endtask

  // receiver side: check results; stall at random outside steady runs
  initial begin
    int hold;
    int roll;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
      if (hold > 0) begin
        hold--;
      end else if (steady_run) begin
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          out_ready <= 1'b1;
          hold = $urandom_range(0, 7);
        end else if (roll < 90) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int sender_gap();
    int roll;
    if (steady_run) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request, wait for its transaction, then queue its result
  task automatic send_request(input logic [2:0] act, input logic [31:0] operand,
                              input logic [5:0] pos, input bit typed,
                              input lifo_result_t want);
    int           gap;
    lifo_result_t pred;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    operand_value  <= operand;
    position_query <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = lifo_response(act, operand, pos);
    responses_due.push_back(typed ? want : pred);
  endtask

  // hold off until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  // operand mix: wide random, a small pool for repeats, and the extremes
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom();
    if (roll < 70) return 32'($urandom_range(0, 7));
    if (roll < 85) return 32'hFFFF_FFF8 | 32'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // search for a held entry most of the time
  function automatic logic [31:0] pick_search_value();
    if (stack_fill > 0 && $urandom_range(0, 99) < 60)
      return 32'(stack_words[$urandom_range(0, stack_fill - 1)]);
    return pick_value();
  endfunction

  function automatic logic [5:0] pick_position();
    if (stack_fill > 0 && $urandom_range(0, 99) < 70)
      return 6'($urandom_range(0, stack_fill - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // build one random request for the current kind of segment
  task automatic random_request(input segment_t kind, output logic [2:0] act,
                                output logic [31:0] operand, output logic [5:0] pos);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      SEG_FILL:  act = (roll < 75) ? ACT_PUSH : (roll < 85) ? ACT_SEARCH :
                       (roll < 95) ? ACT_READ : 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      SEG_DRAIN: act = (roll < 75) ? ACT_POP : (roll < 85) ? ACT_SEARCH :
                       (roll < 95) ? ACT_READ : 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      default:   act = (roll < 30) ? ACT_PUSH : (roll < 50) ? ACT_POP :
                       (roll < 70) ? ACT_SEARCH : (roll < 90) ? ACT_READ :
                       (roll < 93) ? ACT_CLEAR :
                       3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    endcase
    operand = (act == ACT_SEARCH) ? pick_search_value() : pick_value();
    pos     = (act == ACT_READ) ? pick_position() : 6'($urandom_range(0, 63));
  endtask

  // stimulus
  initial begin
    int          sent;
    int          spill;
    int          seg_len;
    bit          was_full;
    bit          was_empty;
    segment_t    kind;
    logic [2:0]  act;
    logic [31:0] operand;
    logic [5:0]  pos;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int row = 0; row < DIR_COUNT; row++)
      send_request(DIRECTED[row].act, DIRECTED[row].operand, DIRECTED[row].pos,
                   DIRECTED[row].typed, DIRECTED[row].want);
    drain_results();

    // random segments; the first one always runs the stack to full
    kind = SEG_FILL;
    while (sent < RANDOM_ITEMS) begin
      steady_run = ($urandom_range(0, 99) < 25);
      case (kind)
        SEG_FILL: begin
          spill = $urandom_range(1, 4);
          while (spill > 0) begin
            random_request(kind, act, operand, pos);
            was_full = (stack_fill == STACK_DEPTH);
            send_request(act, operand, pos, 1'b0, '0);
            sent++;
            if (was_full && act == ACT_PUSH) spill--;
          end
        end
        SEG_DRAIN: begin
          spill = $urandom_range(1, 2);
          while (spill > 0) begin
            random_request(kind, act, operand, pos);
            was_empty = (stack_fill == 0);
            send_request(act, operand, pos, 1'b0, '0);
            sent++;
            if (was_empty && act == ACT_POP) spill--;
          end
        end
        default: begin
          seg_len = $urandom_range(20, 60);
          repeat (seg_len) begin
            random_request(kind, act, operand, pos);
            send_request(act, operand, pos, 1'b0, '0);
            sent++;
          end
        end
      endcase
      if ($urandom_range(0, 99) < 15) drain_results();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: kind = SEG_FILL;
        6, 7, 8, 9, 10:   kind = SEG_DRAIN;
        default:          kind = SEG_MIX;
      endcase
    end

    // wait out the remaining results and the block's latency
    steady_run = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[searchable_lifo_stack_core] OK");
    end else begin
      $display("[searchable_lifo_stack_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lstk_pkg.sv
src/lstk_cell.sv
src/lstk_ctrl.sv
src/searchable_lifo_stack_core.sv
verif/tb_top.sv
